[hw/rtl/alarm_annunciator_sequencer_macros.svh]
// Assertion macros used by the annunciator top level.
`ifndef ALARM_ANNUNCIATOR_SEQUENCER_MACROS_SVH
`define ALARM_ANNUNCIATOR_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define AAS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("annunciator same-cycle check failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define AAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("annunciator next-cycle check failed");
`else
`define AAS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define AAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/aas_pkg.sv]
`default_nettype none

package aas_pkg;

  // Sequence shape.
  localparam int SEQ_STEPS     = 16;
  localparam int SWEEP_STEPS   = 8;
  localparam int STEPS_PER_LED = 1;
  localparam int GAP_TICKS     = 150;

  localparam int SEQ_W   = $clog2(SEQ_STEPS);
  localparam int SWEEP_W = (SWEEP_STEPS > 1) ? $clog2(SWEEP_STEPS) : 1;
  localparam int LED_W   = (STEPS_PER_LED > 1) ? $clog2(STEPS_PER_LED) : 1;

  // Field and register widths.
  localparam int T16_W      = 16;
  localparam int T20_W      = 20;
  localparam int STEPS_W    = 5;
  localparam int CMP_W      = (SEQ_W > STEPS_W) ? SEQ_W : STEPS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_TICKS   = 3'd0,
    REG_BUZZ_STEPS   = 3'd1,
    REG_RED_STEPS    = 3'd2,
    REG_RINGDOWN     = 3'd3,
    REG_CHIRP_PERIOD = 3'd4,
    REG_CHIRP_TICKS  = 3'd5,
    REG_BEAT_PERIOD  = 3'd6,
    REG_BEAT_FLASH   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    HB_OFF    = 2'd0,
    HB_SINGLE = 2'd1,
    HB_DOUBLE = 2'd2,
    HB_ALT    = 2'd3
  } hb_mode_e;

  typedef enum logic [1:0] {
    RED_OFF  = 2'd0,
    RED_FULL = 2'd1,
    RED_DIM  = 2'd2,
    RED_RSVD = 2'd3
  } red_e;

  typedef enum logic [1:0] {
    BEAT_QUIET  = 2'd0,
    BEAT_FLASH1 = 2'd1,
    BEAT_GAP    = 2'd2,
    BEAT_FLASH2 = 2'd3
  } beat_e;

  typedef struct packed {
    logic [T16_W-1:0]   step_ticks;
    logic [STEPS_W-1:0] buzz_steps;
    logic [STEPS_W-1:0] red_steps;
    logic [T16_W-1:0]   ringdown_ticks;
    logic [T20_W-1:0]   chirp_period_ticks;
    logic [T16_W-1:0]   chirp_ticks;
    logic [T20_W-1:0]   beat_period_ticks;
    logic [T16_W-1:0]   beat_flash_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] heartbeat_mode;
    logic       battery_enable;
    logic       chase_enable;
    logic       buzzer_enable;
  } in_item_t;

  typedef struct packed {
    logic       sensor_blank;
    logic       chase_advance_pulse;
    logic       chase_reset_pulse;
    logic [1:0] red_led;
    logic       piezo_drive;
  } out_item_t;

  function automatic logic [T16_W-1:0] sat_inc16(input logic [T16_W-1:0] v);
    return (v == {T16_W{1'b1}}) ? v : v + T16_W'(1);
  endfunction

  function automatic logic [T20_W-1:0] sat_inc20(input logic [T20_W-1:0] v);
    return (v == {T20_W{1'b1}}) ? v : v + T20_W'(1);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/aas_cfg_regs.sv]
`default_nettype none

module aas_cfg_regs
  import aas_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_reg_e'(wr_index))
        REG_STEP_TICKS:   cfg_nxt.step_ticks         = wr_data[T16_W-1:0];
        REG_BUZZ_STEPS:   cfg_nxt.buzz_steps         = wr_data[STEPS_W-1:0];
        REG_RED_STEPS:    cfg_nxt.red_steps          = wr_data[STEPS_W-1:0];
        REG_RINGDOWN:     cfg_nxt.ringdown_ticks     = wr_data[T16_W-1:0];
        REG_CHIRP_PERIOD: cfg_nxt.chirp_period_ticks = wr_data[T20_W-1:0];
        REG_CHIRP_TICKS:  cfg_nxt.chirp_ticks        = wr_data[T16_W-1:0];
        REG_BEAT_PERIOD:  cfg_nxt.beat_period_ticks  = wr_data[T20_W-1:0];
        REG_BEAT_FLASH:   cfg_nxt.beat_flash_ticks   = wr_data[T16_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_ticks         <= T16_W'(50);
      cfg_r.buzz_steps         <= STEPS_W'(3);
      cfg_r.red_steps          <= STEPS_W'(4);
      cfg_r.ringdown_ticks     <= T16_W'(30);
      cfg_r.chirp_period_ticks <= T20_W'(45000);
      cfg_r.chirp_ticks        <= T16_W'(80);
      cfg_r.beat_period_ticks  <= T20_W'(3000);
      cfg_r.beat_flash_ticks   <= T16_W'(50);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hw/rtl/aas_tick_core.sv]
`default_nettype none

module aas_tick_core
  import aas_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     tick_en,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  // Sequencer state. sweep_pos_r and led_pos_r track step_idx_r modulo the
  // sweep length and the steps per LED, so no divider is needed.
  logic [SEQ_W-1:0]   step_idx_r,  step_idx_nxt;
  logic [SWEEP_W-1:0] sweep_pos_r, sweep_pos_nxt;
  logic [LED_W-1:0]   led_pos_r,   led_pos_nxt;
  logic [T16_W-1:0]   step_el_r,   step_el_nxt;
  logic               beep_r,      beep_nxt;
  logic               red_ph_r,    red_ph_nxt;
  logic               a_rd_act_r,  a_rd_act_nxt;
  logic [T16_W-1:0]   a_rd_el_r,   a_rd_el_nxt;
  logic               blank_r,     blank_nxt;
  logic               chirping_r,  chirping_nxt;
  logic [T20_W-1:0]   chirp_el_r,  chirp_el_nxt;
  logic               c_rd_act_r,  c_rd_act_nxt;
  logic [T16_W-1:0]   c_rd_el_r,   c_rd_el_nxt;
  beat_e              beat_r,      beat_nxt;
  logic [T20_W-1:0]   beat_el_r,   beat_el_nxt;
  in_item_t           prev_r,      prev_nxt;

  logic       alarm;
  logic       rst_pulse;
  logic       adv_pulse;
  logic [1:0] red_code;

  always_comb begin
    alarm     = item.buzzer_enable | item.chase_enable;
    rst_pulse = 1'b0;
    adv_pulse = 1'b0;

    step_idx_nxt  = step_idx_r;
    sweep_pos_nxt = sweep_pos_r;
    led_pos_nxt   = led_pos_r;
    beep_nxt      = beep_r;
    red_ph_nxt    = red_ph_r;
    a_rd_act_nxt  = a_rd_act_r;
    blank_nxt     = blank_r;
    chirping_nxt  = chirping_r;
    c_rd_act_nxt  = c_rd_act_r;
    beat_nxt      = beat_r;
    prev_nxt      = item;

    // Timers, all saturating; the ringdown timers advance only while active.
    step_el_nxt  = sat_inc16(step_el_r);
    chirp_el_nxt = sat_inc20(chirp_el_r);
    beat_el_nxt  = sat_inc20(beat_el_r);
    a_rd_el_nxt  = a_rd_act_r ? sat_inc16(a_rd_el_r) : a_rd_el_r;
    c_rd_el_nxt  = c_rd_act_r ? sat_inc16(c_rd_el_r) : c_rd_el_r;

    // Control edges.
    if (item.heartbeat_mode != prev_r.heartbeat_mode) begin
      beat_nxt    = BEAT_QUIET;
      beat_el_nxt = '0;
    end
    if (prev_r.buzzer_enable && !item.buzzer_enable) begin
      blank_nxt = 1'b0;
    end
    if (prev_r.chase_enable && !item.chase_enable) begin
      rst_pulse = 1'b1;
    end
    if (!prev_r.battery_enable && item.battery_enable) begin
      chirp_el_nxt = cfg.chirp_period_ticks;
    end
    if (prev_r.battery_enable && !item.battery_enable && !alarm) begin
      blank_nxt = 1'b0;
    end

    // Master alarm sequence.
    if (!alarm) begin
      step_idx_nxt  = '0;
      sweep_pos_nxt = '0;
      led_pos_nxt   = '0;
      a_rd_act_nxt  = 1'b0;
      beep_nxt      = 1'b0;
      blank_nxt     = 1'b0;
    end else begin
      if (step_el_nxt >= cfg.step_ticks) begin
        step_el_nxt = '0;
        if (sweep_pos_r == '0) begin
          rst_pulse = 1'b1;
          if (item.chase_enable) begin
            adv_pulse = 1'b1;
          end
        end else if (item.chase_enable && (led_pos_r == '0)) begin
          adv_pulse = 1'b1;
        end
        beep_nxt   = CMP_W'(step_idx_r) < CMP_W'(cfg.buzz_steps);
        red_ph_nxt = CMP_W'(step_idx_r) < CMP_W'(cfg.red_steps);
        if (step_idx_r == SEQ_W'(SEQ_STEPS - 1)) begin
          step_idx_nxt  = '0;
          sweep_pos_nxt = '0;
          led_pos_nxt   = '0;
        end else begin
          step_idx_nxt  = step_idx_r + SEQ_W'(1);
          sweep_pos_nxt = (sweep_pos_r == SWEEP_W'(SWEEP_STEPS - 1)) ? '0
                                                                     : sweep_pos_r + SWEEP_W'(1);
          led_pos_nxt   = (led_pos_r == LED_W'(STEPS_PER_LED - 1)) ? '0
                                                                   : led_pos_r + LED_W'(1);
        end
      end
      if (!item.buzzer_enable) begin
        blank_nxt = 1'b0;
      end else if (beep_nxt) begin
        blank_nxt    = 1'b1;
        a_rd_act_nxt = 1'b0;
      end else begin
        if (!a_rd_act_nxt) begin
          a_rd_act_nxt = 1'b1;
          a_rd_el_nxt  = '0;
        end
        if (a_rd_el_nxt >= cfg.ringdown_ticks) begin
          blank_nxt = 1'b0;
        end
      end
    end

    // Low-battery chirp.
    if (!item.battery_enable) begin
      chirping_nxt = 1'b0;
      c_rd_act_nxt = 1'b0;
    end else if (alarm) begin
      chirping_nxt = 1'b0;
      c_rd_act_nxt = 1'b0;
      chirp_el_nxt = '0;
    end else begin
      if (!chirping_nxt) begin
        if (chirp_el_nxt >= cfg.chirp_period_ticks) begin
          chirping_nxt = 1'b1;
          chirp_el_nxt = '0;
          blank_nxt    = 1'b1;
          c_rd_act_nxt = 1'b0;
        end
      end else if (chirp_el_nxt >= T20_W'(cfg.chirp_ticks)) begin
        chirping_nxt = 1'b0;
        chirp_el_nxt = '0;
        c_rd_act_nxt = 1'b1;
        c_rd_el_nxt  = '0;
      end
      if (c_rd_act_nxt && (c_rd_el_nxt >= cfg.ringdown_ticks)) begin
        c_rd_act_nxt = 1'b0;
        if (!item.buzzer_enable) begin
          blank_nxt = 1'b0;
        end
      end
    end

    // Idle heartbeat.
    if ((hb_mode_e'(item.heartbeat_mode) == HB_OFF) || alarm || chirping_nxt) begin
      beat_nxt    = BEAT_QUIET;
      beat_el_nxt = '0;
    end else begin
      unique case (beat_nxt)
        BEAT_QUIET: begin
          if (beat_el_nxt >= cfg.beat_period_ticks) begin
            beat_el_nxt = '0;
            beat_nxt    = BEAT_FLASH1;
          end
        end
        BEAT_FLASH1: begin
          if (beat_el_nxt >= T20_W'(cfg.beat_flash_ticks)) begin
            beat_el_nxt = '0;
            beat_nxt    = (hb_mode_e'(item.heartbeat_mode) == HB_DOUBLE) ? BEAT_GAP
                                                                         : BEAT_QUIET;
          end
        end
        BEAT_GAP: begin
          if (beat_el_nxt >= T20_W'(GAP_TICKS)) begin
            beat_el_nxt = '0;
            beat_nxt    = BEAT_FLASH2;
          end
        end
        BEAT_FLASH2: begin
          if (beat_el_nxt >= T20_W'(cfg.beat_flash_ticks)) begin
            beat_el_nxt = '0;
            beat_nxt    = BEAT_QUIET;
          end
        end
      endcase
    end

    if (alarm) begin
      red_code = (item.chase_enable && red_ph_nxt) ? RED_FULL : RED_OFF;
    end else if (chirping_nxt) begin
      red_code = RED_FULL;
    end else if ((beat_nxt == BEAT_FLASH1) || (beat_nxt == BEAT_FLASH2)) begin
      red_code = RED_DIM;
    end else begin
      red_code = RED_OFF;
    end

    result.piezo_drive         = (item.buzzer_enable & beep_nxt) | chirping_nxt;
    result.red_led             = red_code;
    result.chase_reset_pulse   = rst_pulse;
    result.chase_advance_pulse = adv_pulse;
    result.sensor_blank        = blank_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_idx_r  <= '0;
      sweep_pos_r <= '0;
      led_pos_r   <= '0;
      step_el_r   <= '1;
      beep_r      <= 1'b0;
      red_ph_r    <= 1'b0;
      a_rd_act_r  <= 1'b0;
      a_rd_el_r   <= '0;
      blank_r     <= 1'b0;
      chirping_r  <= 1'b0;
      chirp_el_r  <= '0;
      c_rd_act_r  <= 1'b0;
      c_rd_el_r   <= '0;
      beat_r      <= BEAT_QUIET;
      beat_el_r   <= '0;
      prev_r      <= '0;
    end else if (tick_en) begin
      step_idx_r  <= step_idx_nxt;
      sweep_pos_r <= sweep_pos_nxt;
      led_pos_r   <= led_pos_nxt;
      step_el_r   <= step_el_nxt;
      beep_r      <= beep_nxt;
      red_ph_r    <= red_ph_nxt;
      a_rd_act_r  <= a_rd_act_nxt;
      a_rd_el_r   <= a_rd_el_nxt;
      blank_r     <= blank_nxt;
      chirping_r  <= chirping_nxt;
      chirp_el_r  <= chirp_el_nxt;
      c_rd_act_r  <= c_rd_act_nxt;
      c_rd_el_r   <= c_rd_el_nxt;
      beat_r      <= beat_nxt;
      beat_el_r   <= beat_el_nxt;
      prev_r      <= prev_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/alarm_annunciator_sequencer.sv]
// Channel   Direction  Signals                                    Content
// in_       slave      in_tvalid, in_tready, in_tdata[7:0]        one tick with control levels
// out_      master     out_tvalid, out_tready, out_tdata[7:0]     one result per tick
// cfg_      slave      cfg_valid, cfg_ready, cfg_index, cfg_data  timing register write
//
// Every tick transaction yields exactly one result transaction, passing through the input
// and output registers; one tick is accepted per cycle while the output is not stalled.
// Throughput is set by the single tick-update stage between the input register and
// the output register; the annunciator state advances only when a tick moves on.
// Reset is synchronous and active low; it restores the default timing values and
// clears the sequencer, chirp and heartbeat state.
// A stalled output holds its transaction while the input register keeps one more tick.
`default_nettype none
`include "alarm_annunciator_sequencer_macros.svh"

module alarm_annunciator_sequencer
  import aas_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Fields from bit 0: buzzer_enable, chase_enable, battery_enable,
  // heartbeat_mode[1:0], then zero padding.
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: piezo_drive, red_led[1:0], chase_reset_pulse,
  // chase_advance_pulse, sensor_blank, then zero padding.
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // Input register: holds the accepted tick until the update stage takes it.
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  // Output register: holds the finished result until the consumer takes it.
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      s1_fire;
  logic      in_fire;
  cfg_t      cfg;
  out_item_t result;

  // The update stage fires when a tick is waiting and the output register is
  // free or is being emptied in this same cycle.
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // Configuration writes are always taken; the user must write only while idle.
  assign cfg_ready = 1'b1;

  aas_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  aas_tick_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (s1_fire),
    .item    (s1_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item_t'(in_tdata[$bits(in_item_t)-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_item_r);

  // A tick leaving the input register always lands in the output register.
  `AAS_ASSERT_NEXT(a_stage_moves, clk, rst_n, s1_fire, out_valid_r)
  // The LED code never takes the reserved value.
  `AAS_ASSERT_SAME(a_red_code, clk, rst_n, out_valid_r, out_item_r.red_led != RED_RSVD)
  // The piezo never sounds while the LED shows the dimmed heartbeat.
  `AAS_ASSERT_SAME(a_piezo_not_beat, clk, rst_n, out_valid_r && out_item_r.piezo_drive,
                   out_item_r.red_led != RED_DIM)

endmodule

`default_nettype wire
